@@ rtl/core/bst_pkg.sv @@
// Shared types and constants for the broadcast subscriber table.
// Used by bst_ctrl, bst_datapath and broadcast_subscriber_table; depends on nothing.
`timescale 1ns / 1ps

package bst_pkg;

   localparam int MAX_SUBSCRIBERS = 16;
   localparam int IDX_W   = (MAX_SUBSCRIBERS > 1) ? $clog2(MAX_SUBSCRIBERS) : 1;
   localparam int ADDR_W  = 32;
   localparam int FLAGS_W = 32;
   localparam int COUNT_W = 5;

   localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(MAX_SUBSCRIBERS - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // request codes
   localparam logic REQ_UPDATE    = 1'b0;
   localparam logic REQ_BROADCAST = 1'b1;

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [FLAGS_W-1:0] flags_type;
   typedef logic [COUNT_W-1:0] count_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // take the request in, restart the scan
      logic step;        // examine the current entry and advance
      logic capture;     // current entry becomes the held recipient
      logic emit_held;   // held recipient goes to the output register, not last
      logic emit_final;  // closing transaction of the request
      logic upd_write;   // commit an update to the table
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last_idx;
      logic hit;
      logic held_valid;
      logic out_free;
   } status_type;

endpackage

@@ rtl/core/bst_datapath.sv @@
// Datapath of the subscriber table: entry storage, scan index, held recipient
// and output register. Depends on bst_pkg.
`timescale 1ns / 1ps

module bst_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  bst_pkg::cmd_type     cmd,
   output bst_pkg::status_type  status,
   input  logic                 req_type,
   input  bst_pkg::addr_type    req_client_addr,
   input  bst_pkg::flags_type   req_flag_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_dest_valid,
   output bst_pkg::addr_type    rsp_dest_address,
   output logic                 rsp_last_result,
   output bst_pkg::count_type   rsp_sent_count,
   output logic                 rsp_update_dropped
);

   bst_pkg::flags_type entry_flags_ff [bst_pkg::MAX_SUBSCRIBERS];
   bst_pkg::addr_type  entry_addr_ff  [bst_pkg::MAX_SUBSCRIBERS];

   logic                req_type_ff;
   bst_pkg::addr_type   client_ff;
   bst_pkg::flags_type  word_ff;
   bst_pkg::idx_type    idx_ff, idx_in;
   bst_pkg::count_type  count_ff, count_in;
   logic                held_valid_ff;
   bst_pkg::addr_type   held_addr_ff;
   bst_pkg::count_type  held_count_ff;
   logic                match_found_ff;
   bst_pkg::idx_type    match_idx_ff;
   logic                free_found_ff;
   bst_pkg::idx_type    free_idx_ff;

   logic                rsp_valid_ff;
   logic                dest_valid_ff;
   bst_pkg::addr_type   dest_addr_ff;
   logic                last_ff;
   bst_pkg::count_type  sent_count_ff;
   logic                dropped_ff;

   bst_pkg::flags_type  cur_flags;
   bst_pkg::addr_type   cur_addr;
   logic                is_bcast;
   logic                occupied;
   logic                hit;
   logic                drop_cond;
   logic                out_free;

   assign cur_flags = entry_flags_ff[idx_ff];
   assign cur_addr  = entry_addr_ff[idx_ff];
   assign is_bcast  = (req_type_ff == bst_pkg::REQ_BROADCAST);
   assign occupied  = (cur_flags != '0);
   assign hit       = is_bcast && ((cur_flags & word_ff) != '0) && (cur_addr != client_ff);
   assign drop_cond = !match_found_ff && (word_ff != '0) && !free_found_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign idx_in   = cmd.load ? '0 : (cmd.step ? idx_ff + bst_pkg::idx_type'(1) : idx_ff);
   assign count_in = (count_ff == bst_pkg::COUNT_MAX) ? count_ff
                                                      : count_ff + bst_pkg::count_type'(1);

   assign status.last_idx   = (idx_ff == bst_pkg::LAST_IDX);
   assign status.hit        = hit;
   assign status.held_valid = held_valid_ff;
   assign status.out_free   = out_free;

   // table: flags carry the free marking and are cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bst_pkg::MAX_SUBSCRIBERS; i++) begin
            entry_flags_ff[i] <= '0;
         end
      end else if (cmd.upd_write && !is_bcast) begin
         if (match_found_ff) begin
            entry_flags_ff[match_idx_ff] <= word_ff;
         end else if ((word_ff != '0) && free_found_ff) begin
            entry_flags_ff[free_idx_ff] <= word_ff;
         end
      end
   end

   // addresses are only meaningful behind nonzero flags
   always_ff @(posedge clock) begin
      if (cmd.upd_write && !is_bcast && !match_found_ff && (word_ff != '0) && free_found_ff) begin
         entry_addr_ff[free_idx_ff] <= client_ff;
      end
   end

   // request, scan and held recipient
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff         <= '0;
         count_ff       <= '0;
         held_valid_ff  <= 1'b0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (cmd.load) begin
            count_ff       <= '0;
            held_valid_ff  <= 1'b0;
            match_found_ff <= 1'b0;
            free_found_ff  <= 1'b0;
         end else begin
            if (cmd.capture) begin
               count_ff      <= count_in;
               held_valid_ff <= 1'b1;
            end
            if (cmd.step && !is_bcast) begin
               if (occupied && (cur_addr == client_ff) && !match_found_ff) begin
                  match_found_ff <= 1'b1;
               end
               if (!occupied && !free_found_ff) begin
                  free_found_ff <= 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_type_ff <= req_type;
         client_ff   <= req_client_addr;
         word_ff     <= req_flag_word;
      end
      if (cmd.capture) begin
         held_addr_ff  <= cur_addr;
         held_count_ff <= count_in;
      end
      if (cmd.step && !is_bcast) begin
         if (occupied && (cur_addr == client_ff) && !match_found_ff) begin
            match_idx_ff <= idx_ff;
         end
         if (!occupied && !free_found_ff) begin
            free_idx_ff <= idx_ff;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_held || cmd.emit_final) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_held) begin
         dest_valid_ff <= 1'b1;
         dest_addr_ff  <= held_addr_ff;
         last_ff       <= 1'b0;
         sent_count_ff <= held_count_ff;
         dropped_ff    <= 1'b0;
      end else if (cmd.emit_final) begin
         dest_valid_ff <= held_valid_ff;
         dest_addr_ff  <= held_valid_ff ? held_addr_ff : '0;
         last_ff       <= 1'b1;
         sent_count_ff <= held_valid_ff ? held_count_ff : '0;
         dropped_ff    <= !is_bcast && drop_cond;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_dest_valid     = dest_valid_ff;
   assign rsp_dest_address   = dest_addr_ff;
   assign rsp_last_result    = last_ff;
   assign rsp_sent_count     = sent_count_ff;
   assign rsp_update_dropped = dropped_ff;

endmodule

@@ rtl/core/bst_ctrl.sv @@
// Controller of the subscriber table: sequences the scan of one request.
// Depends on bst_pkg.
`timescale 1ns / 1ps

module bst_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bst_pkg::status_type  status,
   output bst_pkg::cmd_type     cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      stall;

   // a second recipient cannot be held while the older one has nowhere to go
   assign stall     = status.hit && status.held_valid && !status.out_free;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               cmd.step      = 1'b1;
               cmd.capture   = status.hit;
               cmd.emit_held = status.hit && status.held_valid;
               if (status.last_idx) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.emit_final = 1'b1;
               cmd.upd_write  = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/broadcast_subscriber_table.sv @@
// Top level of the broadcast subscriber table: controller plus datapath.
// Depends on bst_pkg, bst_ctrl and bst_datapath.
`timescale 1ns / 1ps

// Keeps up to MAX_SUBSCRIBERS (16) entries of client address and flag word; zero
// flags mark an entry free. An update (req_type 0) overwrites the flags of the
// occupied entry with the same address (zero removes it), or else fills the first
// free entry, and answers with one transaction flagging update_dropped when the
// table was full. A broadcast (req_type 1) answers with one transaction per entry
// whose flags share a bit with the mask and whose address is not the requester's,
// in table order, the last one marked and carrying the total in sent_count; with no
// recipient a single empty last transaction is given. Each request is handled by a
// scan that reads one entry per cycle while the output is not stalled; back-pressure
// on rsp_ready only stretches the scan. A new request is taken as soon as the final
// response has been loaded into the output register.

module broadcast_subscriber_table (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_type,
   input  bst_pkg::addr_type   req_client_addr,
   input  bst_pkg::flags_type  req_flag_word,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_dest_valid,
   output bst_pkg::addr_type   rsp_dest_address,
   output logic                rsp_last_result,
   output bst_pkg::count_type  rsp_sent_count,
   output logic                rsp_update_dropped
);

   bst_pkg::cmd_type    cmd;
   bst_pkg::status_type status;

   // sequencing: idle -> scan of every entry -> final transaction
   bst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // storage, compare and the single output register
   bst_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_type           (req_type),
      .req_client_addr    (req_client_addr),
      .req_flag_word      (req_flag_word),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_dest_valid     (rsp_dest_valid),
      .rsp_dest_address   (rsp_dest_address),
      .rsp_last_result    (rsp_last_result),
      .rsp_sent_count     (rsp_sent_count),
      .rsp_update_dropped (rsp_update_dropped)
   );

   // one request at a time
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a scan was in progress");

   // only the closing transaction may lack a recipient
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_dest_valid |-> rsp_last_result)
      else $error("empty transaction not marked last");

   // every recipient is counted
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dest_valid |-> rsp_sent_count != '0)
      else $error("recipient with zero count");

   // a dropped update never names a recipient
   a_drop_no_dest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_update_dropped |-> !rsp_dest_valid && rsp_last_result)
      else $error("dropped flag on a broadcast transaction");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for broadcast_subscriber_table: directed and random traffic,
// with a cycle-free predictor of the subscriber table and an in-order result check.
// Depends on bst_pkg and the broadcast_subscriber_table RTL.
`timescale 1ns / 1ps

module testbench;

   // No acceptance on either channel for this many cycles means the block has hung.
   localparam int WATCHDOG_LIMIT = 1000;
   // Cycles of receiver hold-off in the back-pressure test.
   localparam int HOLD_OFF_CYCLES = 80;
   // Settling time after the last result: one full scan plus margin.
   localparam int SETTLE_CYCLES = bst_pkg::MAX_SUBSCRIBERS + 6;
   localparam int POOL_SIZE = bst_pkg::MAX_SUBSCRIBERS + 6;

   // One result transaction, as seen on the rsp_ ports.
   typedef struct packed {
      logic               dest_valid;
      bst_pkg::addr_type  dest_address;
      logic               last_result;
      bst_pkg::count_type sent_count;
      logic               update_dropped;
   } dest_result_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_type;
   bst_pkg::addr_type   req_client_addr;
   bst_pkg::flags_type  req_flag_word;
   logic                rsp_valid;
   logic                rsp_ready;
   logic                rsp_dest_valid;
   bst_pkg::addr_type   rsp_dest_address;
   logic                rsp_last_result;
   bst_pkg::count_type  rsp_sent_count;
   logic                rsp_update_dropped;

   // Predictor's own copy of the table; zero flags mean the slot is free.
   bst_pkg::addr_type   sub_address [bst_pkg::MAX_SUBSCRIBERS];
   bst_pkg::flags_type  sub_flags   [bst_pkg::MAX_SUBSCRIBERS];

   // Results owed by the block, oldest first.
   dest_result_type pending_results[$];

   int error_count      = 0;
   int results_checked  = 0;
   int updates_sent     = 0;
   int broadcasts_sent  = 0;
   int recipients_seen  = 0;
   int drops_seen       = 0;
   int quiet_cycles     = 0;

   // Shared with the receiver process.
   bit gaps_enabled      = 1'b1;
   int hold_off_request  = 0;

   broadcast_subscriber_table uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_client_addr    (req_client_addr),
      .req_flag_word      (req_flag_word),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_dest_valid     (rsp_dest_valid),
      .rsp_dest_address   (rsp_dest_address),
      .rsp_last_result    (rsp_last_result),
      .rsp_sent_count     (rsp_sent_count),
      .rsp_update_dropped (rsp_update_dropped)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Predictor: applies one accepted request to the table copy and queues the
   // results that it owes.
   // ---------------------------------------------------------------------------------
   function automatic void predict_request(input logic kind, input bst_pkg::addr_type addr,
                                           input bst_pkg::flags_type flags);
      dest_result_type res;
      bit              done;
      int              count;
      res   = '0;
      done  = 1'b0;
      count = 0;
      if (kind == bst_pkg::REQ_UPDATE) begin
         // an occupied entry with the same address takes the new flags
         for (int i = 0; i < bst_pkg::MAX_SUBSCRIBERS; i++) begin
            if (!done && sub_flags[i] != '0 && sub_address[i] == addr) begin
               sub_flags[i] = flags;
               done = 1'b1;
            end
         end
         // otherwise the first free entry, unless this is a removal
         if (!done && flags != '0) begin
            for (int i = 0; i < bst_pkg::MAX_SUBSCRIBERS; i++) begin
               if (!done && sub_flags[i] == '0) begin
                  sub_address[i] = addr;
                  sub_flags[i]   = flags;
                  done = 1'b1;
               end
            end
            res.update_dropped = !done;
         end
         res.last_result = 1'b1;
         pending_results.push_back(res);
      end else begin
         for (int i = 0; i < bst_pkg::MAX_SUBSCRIBERS; i++) begin
            if ((sub_flags[i] & flags) != '0 && sub_address[i] != addr) begin
               count++;
               res.dest_valid   = 1'b1;
               res.dest_address = sub_address[i];
               res.sent_count   = (count > int'(bst_pkg::COUNT_MAX))
                                  ? bst_pkg::COUNT_MAX : bst_pkg::count_type'(count);
               pending_results.push_back(res);
            end
         end
         if (count == 0) begin
            res.last_result = 1'b1;
            pending_results.push_back(res);
         end else begin
            // mark the closing transaction
            res = pending_results.pop_back();
            res.last_result = 1'b1;
            pending_results.push_back(res);
         end
      end
   endfunction

   // An address that no occupied entry holds.
   function automatic bst_pkg::addr_type unused_address();
      bst_pkg::addr_type candidate;
      bit                taken;
      do begin
         candidate = $urandom;
         taken = 1'b0;
         for (int i = 0; i < bst_pkg::MAX_SUBSCRIBERS; i++)
            if (sub_flags[i] != '0 && sub_address[i] == candidate) taken = 1'b1;
      end while (taken);
      return candidate;
   endfunction

   // ---------------------------------------------------------------------------------
   // Request driver. Payload changes at the falling edge; acceptance is seen at the
   // rising edge. Valid is left high afterwards so back-to-back requests have no gap.
   // ---------------------------------------------------------------------------------
   task automatic send_request(input logic kind, input bst_pkg::addr_type addr,
                               input bst_pkg::flags_type flags);
      int gap;
      if (gaps_enabled && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         repeat (gap) begin
            @(negedge clock);
            req_valid = 1'b0;
         end
      end
      @(negedge clock);
      req_valid       = 1'b1;
      req_type        = kind;
      req_client_addr = addr;
      req_flag_word   = flags;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_request(kind, addr, flags);
      if (kind == bst_pkg::REQ_UPDATE) updates_sent++;
      else broadcasts_sent++;
   endtask

   // Drops valid and waits until every owed result has come back.
   task automatic wait_for_responses();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------
   // Receiver: random stall bursts, plus a long hold-off when a test asks for one.
   // ---------------------------------------------------------------------------------
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request > 0) begin
            hold_left = hold_off_request;
            hold_off_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else if (gaps_enabled && $urandom_range(0, 4) == 0) begin
            rsp_ready  = 1'b0;
            stall_left = $urandom_range(1, 3) - 1;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Result checker: every accepted transaction against the oldest expectation.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      dest_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result: dest_valid=%0b dest_address=%h last=%0b",
                     $time, rsp_dest_valid, rsp_dest_address, rsp_last_result);
            $display("%0t: unexpected result: count=%0d dropped=%0b",
                     $time, rsp_sent_count, rsp_update_dropped);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_dest_valid !== want.dest_valid) begin
               $display("%0t: dest_valid expected %0b actual %0b",
                        $time, want.dest_valid, rsp_dest_valid);
               error_count++;
            end
            if (rsp_dest_address !== want.dest_address) begin
               $display("%0t: dest_address expected %h actual %h",
                        $time, want.dest_address, rsp_dest_address);
               error_count++;
            end
            if (rsp_last_result !== want.last_result) begin
               $display("%0t: last_result expected %0b actual %0b",
                        $time, want.last_result, rsp_last_result);
               error_count++;
            end
            if (rsp_sent_count !== want.sent_count) begin
               $display("%0t: sent_count expected %0d actual %0d",
                        $time, want.sent_count, rsp_sent_count);
               error_count++;
            end
            if (rsp_update_dropped !== want.update_dropped) begin
               $display("%0t: update_dropped expected %0b actual %0b",
                        $time, want.update_dropped, rsp_update_dropped);
               error_count++;
            end
            if (want.dest_valid) recipients_seen++;
            if (want.update_dropped) drops_seen++;
         end
      end
   end

   // Watchdog: ends a hung run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Empty table: no recipient, removal of an absent client, zero mask.
   task automatic test_empty_table();
      send_request(bst_pkg::REQ_BROADCAST, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(bst_pkg::REQ_UPDATE,    32'h1234_5678, 32'h0000_0000);
      send_request(bst_pkg::REQ_BROADCAST, 32'hFFFF_FFFF, 32'h0000_0000);
      wait_for_responses();
   endtask

   // Insert, overwrite, remove; requester exclusion; free slots keep a stale address.
   task automatic test_update_paths();
      send_request(bst_pkg::REQ_UPDATE,    32'h0000_0000, 32'hFFFF_FFFF);
      send_request(bst_pkg::REQ_UPDATE,    32'hFFFF_FFFF, 32'h8000_0000);
      send_request(bst_pkg::REQ_UPDATE,    32'hA5A5_A5A5, 32'h0000_0001);
      send_request(bst_pkg::REQ_BROADCAST, 32'h5A5A_5A5A, 32'hFFFF_FFFF);
      // requester left out
      send_request(bst_pkg::REQ_BROADCAST, 32'h0000_0000, 32'h8000_0001);
      // overwrite
      send_request(bst_pkg::REQ_UPDATE,    32'hFFFF_FFFF, 32'h0000_0002);
      // old class gone
      send_request(bst_pkg::REQ_BROADCAST, 32'h5A5A_5A5A, 32'h8000_0000);
      // removal
      send_request(bst_pkg::REQ_UPDATE,    32'h0000_0000, 32'h0000_0000);
      // free slot skipped
      send_request(bst_pkg::REQ_BROADCAST, 32'h5A5A_5A5A, 32'hFFFF_FFFF);
      send_request(bst_pkg::REQ_BROADCAST, 32'h0000_0000, 32'hFFFF_FFFF);
      // back into slot 0
      send_request(bst_pkg::REQ_UPDATE,    32'h0000_0000, 32'h0001_0000);
      send_request(bst_pkg::REQ_BROADCAST, 32'h5A5A_5A5A, 32'h0000_0000);
      wait_for_responses();
   endtask

   // Fill the table, overflow it, broadcast to everyone, then free and reuse a slot.
   task automatic test_table_full();
      bst_pkg::flags_type flags;
      int                 used;
      int                 slot;
      used = 0;
      for (int i = 0; i < bst_pkg::MAX_SUBSCRIBERS; i++) if (sub_flags[i] != '0) used++;
      repeat (bst_pkg::MAX_SUBSCRIBERS - used) begin
         flags = $urandom;
         if (flags == '0) flags = 32'h0000_0001;
         send_request(bst_pkg::REQ_UPDATE, unused_address(), flags);
      end
      // both dropped
      send_request(bst_pkg::REQ_UPDATE, unused_address(), 32'hFFFF_FFFF);
      send_request(bst_pkg::REQ_UPDATE, unused_address(), 32'h0000_0001);
      // overwrite when full
      slot = $urandom_range(0, bst_pkg::MAX_SUBSCRIBERS - 1);
      send_request(bst_pkg::REQ_UPDATE, sub_address[slot], 32'hFFFF_FFFF);
      send_request(bst_pkg::REQ_BROADCAST, unused_address(), 32'hFFFF_FFFF);
      slot = $urandom_range(0, bst_pkg::MAX_SUBSCRIBERS - 1);
      send_request(bst_pkg::REQ_UPDATE, sub_address[slot], 32'h0000_0000);
      // takes the freed slot
      send_request(bst_pkg::REQ_UPDATE, unused_address(), 32'h0000_0100);
      wait_for_responses();
   endtask

   // Receiver holds off while full-table broadcasts keep coming; input must stall.
   task automatic test_back_pressure();
      hold_off_request = HOLD_OFF_CYCLES;
      repeat (5) send_request(bst_pkg::REQ_BROADCAST, unused_address(), 32'hFFFF_FFFF);
      wait_for_responses();
   endtask

   // Mixed traffic over a small address pool, so updates hit, miss, remove and drop.
   task automatic test_random_traffic(input int items, input bit gaps);
      bst_pkg::addr_type  pool [POOL_SIZE];
      bst_pkg::addr_type  addr;
      bst_pkg::flags_type flags;
      int                 pick;
      gaps_enabled = gaps;
      for (int i = 0; i < bst_pkg::MAX_SUBSCRIBERS; i++) pool[i] = sub_address[i];
      pool[bst_pkg::MAX_SUBSCRIBERS]     = 32'h0000_0000;
      pool[bst_pkg::MAX_SUBSCRIBERS + 1] = 32'hFFFF_FFFF;
      for (int i = bst_pkg::MAX_SUBSCRIBERS + 2; i < POOL_SIZE; i++) pool[i] = $urandom;
      repeat (items) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            addr = pool[$urandom_range(0, POOL_SIZE - 1)];
            pick = $urandom_range(0, 3);
            if (pick == 0) flags = '0;
            else if (pick == 1)
               flags = bst_pkg::flags_type'(1) << $urandom_range(0, bst_pkg::FLAGS_W - 1);
            else flags = $urandom;
            send_request(bst_pkg::REQ_UPDATE, addr, flags);
         end else begin
            addr = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, POOL_SIZE - 1)]
                                               : bst_pkg::addr_type'($urandom);
            pick = $urandom_range(0, 9);
            if (pick == 0) flags = '0;
            else if (pick < 3) flags = '1;
            else if (pick < 6)
               flags = bst_pkg::flags_type'(1) << $urandom_range(0, bst_pkg::FLAGS_W - 1);
            else flags = $urandom;
            send_request(bst_pkg::REQ_BROADCAST, addr, flags);
         end
      end
      wait_for_responses();
   endtask

   initial begin
      for (int i = 0; i < bst_pkg::MAX_SUBSCRIBERS; i++) begin
         sub_address[i] = '0;
         sub_flags[i]   = '0;
      end
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_type        = bst_pkg::REQ_UPDATE;
      req_client_addr = '0;
      req_flag_word   = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_table();
      test_update_paths();
      test_table_full();
      test_back_pressure();
      test_random_traffic(40, 1'b1);
      // closing stretch runs flat out on both sides
      test_random_traffic(20, 1'b0);

      // let any stray transaction surface before the verdict
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d updates (%0d dropped) and %0d broadcasts",
               updates_sent, drops_seen, broadcasts_sent);
      $display("reaching %0d recipients; %0d results checked, %0d mismatches.",
               recipients_seen, results_checked, error_count);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
